// ===== src/pwm_heartbeat_monitor_defines.svh =====
// Assertion macros for the heartbeat monitor.
// Define NO_ASSERTIONS to compile them out.
`ifndef PWM_HEARTBEAT_MONITOR_DEFINES_SVH
`define PWM_HEARTBEAT_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PHM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phm: same-cycle check failed");
`define PHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phm: next-cycle check failed");
`else
`define PHM_ASSERT_NOW(label, clk, rst, ante, cons)
`define PHM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/phm_pkg.sv =====
package phm_pkg;

  localparam int OUT_W      = 16;
  localparam int CLK_W      = 8;
  localparam int CFG_W      = 16;
  localparam int US_PER_S   = 1000000;
  localparam int MS_SCALE   = 1000;
  // clock_mhz * 1e6 fits in 28 bits, clock_mhz * 1000 in 18 bits
  localparam int FREQ_NUM_W = 28;
  localparam int HIGH_DEN_W = 18;
  localparam int ADDR_W     = 5;
  localparam int APB_W      = 32;

  localparam logic [CLK_W-1:0] CLOCK_MHZ_RST     = 8'd100;
  localparam logic [CFG_W-1:0] FREQ_MIN_RST      = 16'd0;
  localparam logic [CFG_W-1:0] FREQ_MAX_RST      = 16'd65535;
  localparam logic [CFG_W-1:0] HIGH_MIN_RST      = 16'd0;
  localparam logic [CFG_W-1:0] HIGH_MAX_RST      = 16'd65535;
  localparam logic [CFG_W-1:0] MISS_LIMIT_RST    = 16'd10;
  localparam logic [CFG_W-1:0] STARTUP_BEGIN_RST = 16'd10;
  localparam logic [CFG_W-1:0] STARTUP_END_RST   = 16'd100;

  typedef enum logic [2:0] {
    DET_INIT,
    DET_STARTUP,
    DET_STARTUP_ERR,
    DET_RUNNING,
    DET_RUNNING_ERR
  } det_state_t;

  typedef enum logic [2:0] {
    REG_CLOCK_MHZ,
    REG_FREQ_MIN_HZ,
    REG_FREQ_MAX_HZ,
    REG_HIGH_MIN_MS,
    REG_HIGH_MAX_MS,
    REG_MISS_LIMIT,
    REG_STARTUP_BEGIN,
    REG_STARTUP_END
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } ctl_state_t;

endpackage

// ===== src/phm_if.sv =====
interface phm_in_if #(
  parameter int TIMER_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [TIMER_WIDTH-1:0] period_time;
  logic [TIMER_WIDTH-1:0] active_time;
  logic                   partner_powered;

  modport source (output valid, output period_time, output active_time,
                  output partner_powered, input ready);
  modport sink   (input valid, input period_time, input active_time,
                  input partner_powered, output ready);
endinterface

interface phm_out_if;
  logic                            valid;
  logic                            ready;
  phm_pkg::det_state_t             det_state;
  logic [phm_pkg::OUT_W-1:0]       frequency_hz;
  logic [phm_pkg::OUT_W-1:0]       high_time_ms;
  logic                            signal_ok;

  modport source (output valid, output det_state, output frequency_hz,
                  output high_time_ms, output signal_ok, input ready);
  modport sink   (input valid, input det_state, input frequency_hz,
                  input high_time_ms, input signal_ok, output ready);
endinterface

// ===== src/phm_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated to OUT_W bits.
module phm_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  output logic                      done,
  output logic [phm_pkg::OUT_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic [NUM_W-1:0]          num_sr;
  logic [DEN_W-1:0]          den_q;
  logic [DEN_W-1:0]          rem;
  logic [phm_pkg::OUT_W-1:0] q;
  logic                      ovf;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, num_sr[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_q};
    rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= num;
      den_q  <= den;
      rem    <= '0;
      q      <= '0;
      ovf    <= 1'b0;
    end else if (cnt != '0) begin
      num_sr <= {num_sr[NUM_W-2:0], 1'b0};
      rem    <= rem_next;
      // a one leaving the top of q means the quotient no longer fits
      ovf    <= ovf | q[phm_pkg::OUT_W-1];
      q      <= {q[phm_pkg::OUT_W-2:0], ge};
    end
  end

  assign done = (cnt == '0);
  assign quo  = ovf ? '1 : q;

endmodule

// ===== src/pwm_heartbeat_monitor.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+------------------------------------------------
// tick     | in  | period_time, active_time, partner_powered
// result   | out | det_state, frequency_hz, high_time_ms, signal_ok
// APB      | in  | register writes at 4*index, reads return value
//
// A tick is taken only in idle; its result beat is loaded once two bit-serial dividers,
// run side by side for 28 and TIMER_WIDTH steps, have both finished. The next tick is
// taken only after that load, when the block is back in idle.
// A finished beat waits in the output register while the next tick runs; a result that
// finds it still full holds until the sink takes the old beat.
// rst (synchronous) restores register defaults and clears all tick state.
`include "pwm_heartbeat_monitor_defines.svh"

module pwm_heartbeat_monitor #(
  parameter int TIMER_WIDTH = 24,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  phm_in_if.sink                      tick,
  phm_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [phm_pkg::ADDR_W-1:0]  paddr,
  input  logic [phm_pkg::APB_W-1:0]   pwdata,
  output logic [phm_pkg::APB_W-1:0]   prdata,
  output logic                        pready
);

  localparam int CMP_W = (COUNT_WIDTH > phm_pkg::CFG_W) ? COUNT_WIDTH : phm_pkg::CFG_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [phm_pkg::CLK_W-1:0] clock_mhz;
  logic [phm_pkg::CFG_W-1:0] freq_min_hz;
  logic [phm_pkg::CFG_W-1:0] freq_max_hz;
  logic [phm_pkg::CFG_W-1:0] high_min_ms;
  logic [phm_pkg::CFG_W-1:0] high_max_ms;
  logic [phm_pkg::CFG_W-1:0] miss_limit_ticks;
  logic [phm_pkg::CFG_W-1:0] startup_begin_ticks;
  logic [phm_pkg::CFG_W-1:0] startup_end_ticks;

  logic              cfg_wr;
  phm_pkg::cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = phm_pkg::cfg_reg_t'(paddr[phm_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_mhz           <= phm_pkg::CLOCK_MHZ_RST;
      freq_min_hz         <= phm_pkg::FREQ_MIN_RST;
      freq_max_hz         <= phm_pkg::FREQ_MAX_RST;
      high_min_ms         <= phm_pkg::HIGH_MIN_RST;
      high_max_ms         <= phm_pkg::HIGH_MAX_RST;
      miss_limit_ticks    <= phm_pkg::MISS_LIMIT_RST;
      startup_begin_ticks <= phm_pkg::STARTUP_BEGIN_RST;
      startup_end_ticks   <= phm_pkg::STARTUP_END_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        phm_pkg::REG_CLOCK_MHZ:     clock_mhz           <= pwdata[phm_pkg::CLK_W-1:0];
        phm_pkg::REG_FREQ_MIN_HZ:   freq_min_hz         <= pwdata[phm_pkg::CFG_W-1:0];
        phm_pkg::REG_FREQ_MAX_HZ:   freq_max_hz         <= pwdata[phm_pkg::CFG_W-1:0];
        phm_pkg::REG_HIGH_MIN_MS:   high_min_ms         <= pwdata[phm_pkg::CFG_W-1:0];
        phm_pkg::REG_HIGH_MAX_MS:   high_max_ms         <= pwdata[phm_pkg::CFG_W-1:0];
        phm_pkg::REG_MISS_LIMIT:    miss_limit_ticks    <= pwdata[phm_pkg::CFG_W-1:0];
        phm_pkg::REG_STARTUP_BEGIN: startup_begin_ticks <= pwdata[phm_pkg::CFG_W-1:0];
        phm_pkg::REG_STARTUP_END:   startup_end_ticks   <= pwdata[phm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      phm_pkg::REG_CLOCK_MHZ:     prdata = phm_pkg::APB_W'(clock_mhz);
      phm_pkg::REG_FREQ_MIN_HZ:   prdata = phm_pkg::APB_W'(freq_min_hz);
      phm_pkg::REG_FREQ_MAX_HZ:   prdata = phm_pkg::APB_W'(freq_max_hz);
      phm_pkg::REG_HIGH_MIN_MS:   prdata = phm_pkg::APB_W'(high_min_ms);
      phm_pkg::REG_HIGH_MAX_MS:   prdata = phm_pkg::APB_W'(high_max_ms);
      phm_pkg::REG_MISS_LIMIT:    prdata = phm_pkg::APB_W'(miss_limit_ticks);
      phm_pkg::REG_STARTUP_BEGIN: prdata = phm_pkg::APB_W'(startup_begin_ticks);
      phm_pkg::REG_STARTUP_END:   prdata = phm_pkg::APB_W'(startup_end_ticks);
      default:                    prdata = '0;
    endcase
  end

  // control
  phm_pkg::ctl_state_t state, state_next;
  logic tick_acc;
  logic out_load;
  logic f_done, h_done;
  logic in_div;

  assign tick_acc = tick.valid && tick.ready;
  assign in_div   = (state == phm_pkg::S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= phm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tick.ready = 1'b0;
    out_load   = 1'b0;
    case (state)
      phm_pkg::S_IDLE: begin
        tick.ready = 1'b1;
        if (tick.valid) state_next = phm_pkg::S_DIV;
      end
      phm_pkg::S_DIV: begin
        if (f_done && h_done) state_next = phm_pkg::S_DONE;
      end
      phm_pkg::S_DONE: begin
        // wait for room in the output register
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = phm_pkg::S_IDLE;
        end
      end
      default: state_next = phm_pkg::S_IDLE;
    endcase
  end

  // tick capture
  logic powered;
  logic zero_in;

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      powered <= tick.partner_powered;
      zero_in <= (tick.period_time == '0) || (tick.active_time == '0) ||
                 (clock_mhz == '0);
    end
  end

  // dividers
  logic [phm_pkg::FREQ_NUM_W-1:0] f_num;
  logic [phm_pkg::HIGH_DEN_W-1:0] h_den;
  logic [phm_pkg::OUT_W-1:0]      f_quo, h_quo;

  assign f_num = phm_pkg::FREQ_NUM_W'(clock_mhz) * phm_pkg::FREQ_NUM_W'(phm_pkg::US_PER_S);
  assign h_den = phm_pkg::HIGH_DEN_W'(clock_mhz) * phm_pkg::HIGH_DEN_W'(phm_pkg::MS_SCALE);

  phm_div #(
    .NUM_W (phm_pkg::FREQ_NUM_W),
    .DEN_W (TIMER_WIDTH)
  ) u_freq_div (
    .clk   (clk),
    .rst   (rst),
    .start (tick_acc),
    .num   (f_num),
    .den   (tick.period_time),
    .done  (f_done),
    .quo   (f_quo)
  );

  // active / mhz / 1000 equals active / (mhz * 1000) in integer division
  phm_div #(
    .NUM_W (TIMER_WIDTH),
    .DEN_W (phm_pkg::HIGH_DEN_W)
  ) u_high_div (
    .clk   (clk),
    .rst   (rst),
    .start (tick_acc),
    .num   (tick.active_time),
    .den   (h_den),
    .done  (h_done),
    .quo   (h_quo)
  );

  // tick state
  logic                   was_powered;
  logic                   startup_active;
  logic [COUNT_WIDTH-1:0] miss_count;
  logic [COUNT_WIDTH-1:0] phase_count;

  logic                      startup_active_next;
  logic [COUNT_WIDTH-1:0]    miss_count_next;
  logic [COUNT_WIDTH-1:0]    phase_count_next;
  logic [COUNT_WIDTH-1:0]    phase_inc;
  logic [phm_pkg::OUT_W-1:0] freq, high;
  logic                      tick_valid;
  logic                      sig_ok;
  phm_pkg::det_state_t       det_next;

  always_comb begin
    if (!was_powered && powered) begin
      startup_active_next = 1'b1;
    end else if (!powered) begin
      startup_active_next = 1'b0;
    end else begin
      startup_active_next = startup_active;
    end

    freq = zero_in ? '0 : f_quo;
    high = zero_in ? '0 : h_quo;

    tick_valid = (freq >= freq_min_hz) && (freq <= freq_max_hz) &&
                 (high >= high_min_ms) && (high <= high_max_ms);

    if (tick_valid) begin
      miss_count_next = '0;
    end else if (miss_count != COUNT_MAX) begin
      miss_count_next = miss_count + 1'b1;
    end else begin
      miss_count_next = miss_count;
    end
    sig_ok = !(CMP_W'(miss_count_next) > CMP_W'(miss_limit_ticks));

    phase_inc = (phase_count != COUNT_MAX) ? phase_count + 1'b1 : phase_count;
    if (!startup_active_next) begin
      phase_count_next = '0;
      det_next         = phm_pkg::DET_INIT;
    end else if (CMP_W'(phase_inc) < CMP_W'(startup_begin_ticks)) begin
      phase_count_next = phase_inc;
      det_next         = phm_pkg::DET_INIT;
    end else if (CMP_W'(phase_inc) > CMP_W'(startup_end_ticks)) begin
      // clamp at the end of startup
      phase_count_next = COUNT_WIDTH'(startup_end_ticks);
      det_next         = sig_ok ? phm_pkg::DET_RUNNING : phm_pkg::DET_RUNNING_ERR;
    end else begin
      phase_count_next = phase_inc;
      det_next         = sig_ok ? phm_pkg::DET_STARTUP : phm_pkg::DET_STARTUP_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_powered    <= 1'b0;
      startup_active <= 1'b0;
      miss_count     <= '0;
      phase_count    <= '0;
    end else if (out_load) begin
      was_powered    <= powered;
      startup_active <= startup_active_next;
      miss_count     <= miss_count_next;
      phase_count    <= phase_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.det_state    <= det_next;
      result.frequency_hz <= freq;
      result.high_time_ms <= high;
      result.signal_ok    <= sig_ok;
    end
  end

  `PHM_ASSERT_NEXT(a_accept_starts_div, clk, rst, tick_acc, in_div && !f_done && !h_done)
  `PHM_ASSERT_NEXT(a_div_finishes, clk, rst, in_div && f_done && h_done, state == phm_pkg::S_DONE)
  `PHM_ASSERT_NOW(a_phase_idle, clk, rst, !startup_active, phase_count == '0)
  `PHM_ASSERT_NEXT(a_load_shows_beat, clk, rst, out_load, result.valid && (state == phm_pkg::S_IDLE))

endmodule

// ===== tb/tb_pwm_heartbeat_monitor.sv =====
module tb_pwm_heartbeat_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW             = 24;
  localparam int ITEMS_PER_SET  = 145;
  localparam int NUM_SETS       = 10;
  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    phm_pkg::det_state_t       st;
    logic [phm_pkg::OUT_W-1:0] freq;
    logic [phm_pkg::OUT_W-1:0] high;
    logic                      ok;
  } beat_t;

  typedef struct packed {
    logic [TW-1:0] per;
    logic [TW-1:0] act;
    logic          pw;
    logic          typed;
    beat_t         want;
  } drow_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [phm_pkg::ADDR_W-1:0] paddr;
  logic [phm_pkg::APB_W-1:0]  pwdata;
  logic [phm_pkg::APB_W-1:0]  prdata;
  logic                       pready;

  phm_in_if #(.TIMER_WIDTH(TW)) tick_ch ();
  phm_out_if res_ch ();

  pwm_heartbeat_monitor #(
    .TIMER_WIDTH(TW),
    .COUNT_WIDTH(16)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register shadow and monitor state as the block should hold them
  logic [15:0] cfg_shadow [8];
  logic        mon_was_powered;
  logic        mon_startup;
  logic [15:0] mon_miss;
  logic [15:0] mon_phase;

  beat_t       expected_beats [$];
  beat_t       want_beat;
  int          mismatches;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          stall_left;
  bit          long_stall_req;
  int          quiet_cycles;

  drow_t       dir_rows [19];
  logic [15:0] plan [8];
  logic        pw_level;
  int          tmp;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic predict_tick(input logic [TW-1:0] per, input logic [TW-1:0] act,
                              input logic pw, output beat_t b);
    logic [63:0] q;
    logic [15:0] mhz;
    logic        in_window;
    mhz = cfg_shadow[phm_pkg::REG_CLOCK_MHZ];
    if (!mon_was_powered && pw) mon_startup = 1'b1;
    else if (!pw) mon_startup = 1'b0;
    mon_was_powered = pw;

    b.freq = '0;
    b.high = '0;
    if (per != 0 && act != 0 && mhz != 0) begin
      q = (64'(mhz) * 64'd1000000) / 64'(per);
      b.freq = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      q = (64'(act) / 64'(mhz)) / 64'd1000;
      b.high = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    end

    in_window = (b.freq >= cfg_shadow[phm_pkg::REG_FREQ_MIN_HZ]) &&
                (b.freq <= cfg_shadow[phm_pkg::REG_FREQ_MAX_HZ]) &&
                (b.high >= cfg_shadow[phm_pkg::REG_HIGH_MIN_MS]) &&
                (b.high <= cfg_shadow[phm_pkg::REG_HIGH_MAX_MS]);
    if (in_window) mon_miss = '0;
    else if (mon_miss != 16'hFFFF) mon_miss = mon_miss + 16'd1;
    b.ok = !(mon_miss > cfg_shadow[phm_pkg::REG_MISS_LIMIT]);

    if (mon_startup) begin
      if (mon_phase != 16'hFFFF) mon_phase = mon_phase + 16'd1;
      if (mon_phase < cfg_shadow[phm_pkg::REG_STARTUP_BEGIN]) begin
        b.st = phm_pkg::DET_INIT;
      end else if (mon_phase > cfg_shadow[phm_pkg::REG_STARTUP_END]) begin
        mon_phase = cfg_shadow[phm_pkg::REG_STARTUP_END];
        b.st = b.ok ? phm_pkg::DET_RUNNING : phm_pkg::DET_RUNNING_ERR;
      end else begin
        b.st = b.ok ? phm_pkg::DET_STARTUP : phm_pkg::DET_STARTUP_ERR;
      end
    end else begin
      mon_phase = '0;
      b.st = phm_pkg::DET_INIT;
    end
  endtask

  // offer one tick, hold until taken, then maybe drop valid for a gap
  task automatic offer_tick(input logic [TW-1:0] per, input logic [TW-1:0] act,
                            input logic pw, input logic typed, input beat_t typed_beat);
    beat_t b;
    tick_ch.valid           <= 1'b1;
    tick_ch.period_time     <= per;
    tick_ch.active_time     <= act;
    tick_ch.partner_powered <= pw;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    predict_tick(per, act, pw, b);
    expected_beats.push_back(typed ? typed_beat : b);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      tick_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task automatic await_results();
    tick_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input phm_pkg::cfg_reg_t r, input logic [15:0] v);
    logic [31:0] word;
    word       = $urandom;
    word[15:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= phm_pkg::ADDR_W'(int'(r) * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_shadow[r] = (r == phm_pkg::REG_CLOCK_MHZ) ? {8'd0, v[7:0]} : v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TW-1:0] pick_period();
    int unsigned mhz, lo, hi, target;
    logic [63:0] p;
    mhz = cfg_shadow[phm_pkg::REG_CLOCK_MHZ];
    lo  = cfg_shadow[phm_pkg::REG_FREQ_MIN_HZ];
    hi  = cfg_shadow[phm_pkg::REG_FREQ_MAX_HZ];
    case ($urandom_range(9))
      0: return '0;
      1: return TW'($urandom);
      2: return TW'($urandom_range(1, 255));
      default: begin
        if (lo == 0) lo = 1;
        if (mhz == 0 || lo > hi) return TW'($urandom_range(1, 1 << 20));
        target = $urandom_range(lo, hi);
        p = (64'(mhz) * 64'd1000000) / 64'(target);
        if (p == 0) p = 1;
        return (p > 64'hFFFFFF) ? 24'hFFFFFF : p[TW-1:0];
      end
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_active();
    int unsigned mhz, lo, hi, ms, scale;
    logic [63:0] a;
    mhz = cfg_shadow[phm_pkg::REG_CLOCK_MHZ];
    lo  = cfg_shadow[phm_pkg::REG_HIGH_MIN_MS];
    hi  = cfg_shadow[phm_pkg::REG_HIGH_MAX_MS];
    case ($urandom_range(9))
      0: return '0;
      1: return TW'($urandom);
      default: begin
        if (mhz == 0) return TW'($urandom_range(1, 1 << 20));
        scale = mhz * 1000;
        // keep the target reachable within the counter width
        if (hi > 32'hFFFFFF / scale) hi = 32'hFFFFFF / scale;
        if (lo > hi) return TW'($urandom_range(1, 1 << 20));
        ms = $urandom_range(lo, hi);
        a = 64'(ms) * scale + $urandom_range(0, scale - 1);
        if (a == 0) a = 1;
        return (a > 64'hFFFFFF) ? 24'hFFFFFF : a[TW-1:0];
      end
    endcase
  endfunction

  // result side: random ready, plus one long hold on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = LONG_STALL - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (res_ch.det_state !== want_beat.st) begin
          $error("det_state: expected %0d, got %0d", want_beat.st, res_ch.det_state);
          mismatches++;
        end
        if (res_ch.frequency_hz !== want_beat.freq) begin
          $error("frequency_hz: expected %0d, got %0d", want_beat.freq, res_ch.frequency_hz);
          mismatches++;
        end
        if (res_ch.high_time_ms !== want_beat.high) begin
          $error("high_time_ms: expected %0d, got %0d", want_beat.high, res_ch.high_time_ms);
          mismatches++;
        end
        if (res_ch.signal_ok !== want_beat.ok) begin
          $error("signal_ok: expected %0d, got %0d", want_beat.ok, res_ch.signal_ok);
          mismatches++;
        end
      end
    end
  end

  // end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
            || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    tick_ch.valid           <= 1'b0;
    tick_ch.period_time     <= '0;
    tick_ch.active_time     <= '0;
    tick_ch.partner_powered <= 1'b0;

    mismatches      = 0;
    stall_left      = 0;
    long_stall_req  = 1'b0;
    quiet_cycles    = 0;
    src_idle_pct    = 21;
    snk_idle_pct    = 64;
    pw_level        = 1'b1;
    mon_was_powered = 1'b0;
    mon_startup     = 1'b0;
    mon_miss        = '0;
    mon_phase       = '0;
    cfg_shadow[phm_pkg::REG_CLOCK_MHZ]     = {8'd0, phm_pkg::CLOCK_MHZ_RST};
    cfg_shadow[phm_pkg::REG_FREQ_MIN_HZ]   = phm_pkg::FREQ_MIN_RST;
    cfg_shadow[phm_pkg::REG_FREQ_MAX_HZ]   = phm_pkg::FREQ_MAX_RST;
    cfg_shadow[phm_pkg::REG_HIGH_MIN_MS]   = phm_pkg::HIGH_MIN_RST;
    cfg_shadow[phm_pkg::REG_HIGH_MAX_MS]   = phm_pkg::HIGH_MAX_RST;
    cfg_shadow[phm_pkg::REG_MISS_LIMIT]    = phm_pkg::MISS_LIMIT_RST;
    cfg_shadow[phm_pkg::REG_STARTUP_BEGIN] = phm_pkg::STARTUP_BEGIN_RST;
    cfg_shadow[phm_pkg::REG_STARTUP_END]   = phm_pkg::STARTUP_END_RST;

    // zero counts, extreme counts, power edges; reset settings throughout
    dir_rows = '{
      '{24'd0,       24'd0,       1'b0, 1'b1, '{phm_pkg::DET_INIT, 16'd0, 16'd0, 1'b1}},
      '{24'd1,       24'hFFFFFF,  1'b0, 1'b1, '{phm_pkg::DET_INIT, 16'd65535, 16'd167, 1'b1}},
      '{24'hFFFFFF,  24'd1,       1'b0, 1'b1, '{phm_pkg::DET_INIT, 16'd5, 16'd0, 1'b1}},
      '{24'd0,       24'd5000,    1'b0, 1'b1, '{phm_pkg::DET_INIT, 16'd0, 16'd0, 1'b1}},
      '{24'd5000,    24'd0,       1'b0, 1'b1, '{phm_pkg::DET_INIT, 16'd0, 16'd0, 1'b1}},
      '{24'd100000,  24'd50000,   1'b1, 1'b1, '{phm_pkg::DET_INIT, 16'd1000, 16'd0, 1'b1}},
      '{24'd100000,  24'd150000,  1'b1, 1'b0, '0},
      '{24'd3,       24'd3,       1'b1, 1'b0, '0},
      '{24'h800000,  24'h7FFFFF,  1'b1, 1'b0, '0},
      '{24'h555555,  24'hAAAAAA,  1'b1, 1'b0, '0},
      '{24'hAAAAAA,  24'h555555,  1'b1, 1'b0, '0},
      '{24'd1525,    24'd1000000, 1'b1, 1'b0, '0},
      '{24'd1526,    24'd100000,  1'b1, 1'b0, '0},
      '{24'd200,     24'hFFFFFF,  1'b1, 1'b0, '0},
      '{24'd1000000, 24'd500000,  1'b1, 1'b0, '0},
      '{24'd10000,   24'd5000,    1'b1, 1'b0, '0},
      '{24'd3,       24'd3,       1'b0, 1'b1, '{phm_pkg::DET_INIT, 16'd65535, 16'd0, 1'b1}},
      '{24'd0,       24'd0,       1'b1, 1'b0, '0},
      '{24'd50000,   24'd25000,   1'b1, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_tick(dir_rows[i].per, dir_rows[i].act, dir_rows[i].pw,
                 dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < NUM_SETS; ph++) begin
      await_results();
      repeat (4) @(posedge clk);
      case (ph)
        0: plan = '{16'd100, 16'd500, 16'd2000, 16'd0, 16'd5, 16'd3, 16'd5, 16'd20};
        1: plan = '{16'd255, 16'd0, 16'd65535, 16'd1, 16'd40, 16'd0, 16'd0, 16'd0};
        2: plan = '{16'd1, 16'd1, 16'd100, 16'd100, 16'd10000, 16'd65535, 16'd65535,
                    16'd65535};
        // zero clock forces both values to zero; begin after end clamps below begin
        3: plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd3, 16'd1};
        // empty frequency window: every tick misses
        4: plan = '{16'd200, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd5, 16'd2, 16'd8};
        default: begin
          plan[phm_pkg::REG_CLOCK_MHZ]     = 16'($urandom_range(1, 255));
          plan[phm_pkg::REG_FREQ_MIN_HZ]   = 16'($urandom_range(0, 2000));
          tmp = plan[phm_pkg::REG_FREQ_MIN_HZ] + $urandom_range(0, 20000);
          plan[phm_pkg::REG_FREQ_MAX_HZ]   = 16'(tmp);
          plan[phm_pkg::REG_HIGH_MIN_MS]   = 16'($urandom_range(0, 10));
          plan[phm_pkg::REG_HIGH_MAX_MS]   = plan[phm_pkg::REG_HIGH_MIN_MS] +
                                             16'($urandom_range(0, 60));
          plan[phm_pkg::REG_MISS_LIMIT]    = 16'($urandom_range(0, 12));
          plan[phm_pkg::REG_STARTUP_BEGIN] = 16'($urandom_range(0, 15));
          plan[phm_pkg::REG_STARTUP_END]   = 16'($urandom_range(0, 40));
        end
      endcase
      for (int r = 0; r < 8; r++) cfg_write(phm_pkg::cfg_reg_t'(r), plan[r]);

      if (ph == 4) begin
        src_idle_pct = 64;
        snk_idle_pct = 21;
      end else if (ph == 7) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (ph == 8 && n == 40) long_stall_req = 1'b1;
        // pause the sender until the block has emptied
        if (ph == 5 && n == 70) await_results();
        if (pw_level) begin
          if ($urandom_range(99) < 3) pw_level = 1'b0;
        end else if ($urandom_range(99) < 40) begin
          pw_level = 1'b1;
        end
        offer_tick(pick_period(), pick_active(), pw_level, 1'b0, '0);
      end
    end

    await_results();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
